[rtl/ucl_pkg.sv]
// Shared types, sizes and codes for the usable channel list builder.
package ucl_pkg;

    localparam int MAX_CHANNELS = 256;
    localparam int MAX_RANGES   = 8;
    localparam int MASK_BYTES   = (MAX_CHANNELS + 7) / 8;

    localparam int CH_W    = $clog2(MAX_CHANNELS);
    localparam int COUNT_W = $clog2(MAX_CHANNELS + 1);
    localparam int RIDX_W  = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
    localparam int MIDX_W  = (MASK_BYTES > 1) ? $clog2(MASK_BYTES) : 1;
    localparam int RP_W    = 4;

    localparam int OP_W          = 3;
    localparam int FIELD_W       = 8;
    localparam int COUNT_FIELD_W = 9;
    localparam int MODE_W        = 2;
    localparam int RCOUNT_W      = 4;
    localparam int CFG_W         = 9;
    localparam int CFG_IDX_W     = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXCLUSION_MODE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_COUNT    = 2'd2;

    localparam logic [MODE_W-1:0] MODE_RANGES = 2'd1;
    localparam logic [MODE_W-1:0] MODE_MASK   = 2'd2;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD_RANGE = 3'd0,
        OP_LOAD_MASK  = 3'd1,
        OP_CLEAR      = 3'd2,
        OP_BUILD      = 3'd3,
        OP_READ       = 3'd4
    } ucl_op_t;

    typedef struct packed {
        logic accept;
        logic rd_done;
    } ucl_cmd_t;

    typedef struct packed {
        logic is_read;
    } ucl_stat_t;

endpackage

[rtl/ucl_list_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
module ucl_list_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 256,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/ucl_ctrl.sv]
// Controller: input and output handshake and the list read sequence.
module ucl_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    output logic             out_valid,
    input  logic             out_stall,
    input  ucl_pkg::ucl_stat_t stat,
    output ucl_pkg::ucl_cmd_t  cmd
);
    import ucl_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   can_take;
    logic   accept;

    // A new transaction may enter when the controller is idle and the result register is empty or drains now.
    assign can_take = (state_reg == ST_IDLE) && !(out_valid_reg && out_stall);
    assign in_stall = !can_take;
    assign accept   = in_valid && can_take;

    assign cmd.accept  = accept;
    assign cmd.rd_done = (state_reg == ST_READ);
    assign out_valid   = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (stat.is_read)
                    begin
                        state_next = ST_READ;
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                    end
                end
            end
            ST_READ:
            begin
                state_next     = ST_IDLE;
                out_valid_next = 1'b1;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

[rtl/ucl_datapath.sv]
// Datapath: configuration, exclusion tables, build state, list store and result register.
module ucl_datapath (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [ucl_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [ucl_pkg::CFG_W-1:0]            cfg_data,
    input  logic [ucl_pkg::OP_W-1:0]             operation,
    input  logic [ucl_pkg::FIELD_W-1:0]          slot,
    input  logic [ucl_pkg::FIELD_W-1:0]          range_start,
    input  logic [ucl_pkg::FIELD_W-1:0]          range_end,
    input  logic [ucl_pkg::FIELD_W-1:0]          mask_bits,
    input  ucl_pkg::ucl_cmd_t                    cmd,
    output ucl_pkg::ucl_stat_t                   stat,
    output logic [ucl_pkg::FIELD_W-1:0]          channel,
    output logic                                 kept,
    output logic [ucl_pkg::FIELD_W-1:0]          position,
    output logic                                 done_res,
    output logic [ucl_pkg::COUNT_FIELD_W-1:0]    usable_count,
    output logic                                 entry_valid
);
    import ucl_pkg::*;

    ucl_op_t op;

    logic [CFG_W-1:0]    chan_count_reg;
    logic [MODE_W-1:0]   mode_reg;
    logic [RCOUNT_W-1:0] range_count_reg;

    logic [FIELD_W-1:0] starts_reg [MAX_RANGES];
    logic [FIELD_W-1:0] ends_reg   [MAX_RANGES];
    logic [FIELD_W-1:0] mask_reg   [MASK_BYTES];

    logic [COUNT_W-1:0] nc_reg, nc_next;
    logic [RP_W-1:0]    rp_reg, rp_next;
    logic               skip_reg, skip_next;
    logic [COUNT_W-1:0] ll_reg, ll_next;
    logic               rd_valid_reg;

    logic [FIELD_W-1:0]       chan_reg, chan_c;
    logic                     kept_reg, kept_c;
    logic [FIELD_W-1:0]       pos_reg, pos_c;
    logic                     done_reg, done_c;
    logic [COUNT_FIELD_W-1:0] count_reg;
    logic                     valid_reg;

    logic [CH_W-1:0]   ch;
    logic              active;
    logic              excluded;
    logic              rp_in_table;
    logic              rp_in_use;
    logic [FIELD_W-1:0] cur_start, cur_end;
    logic              ram_we;
    logic [CH_W-1:0]   ram_q;
    logic              rd_ok;

    assign op           = ucl_op_t'(operation);
    assign stat.is_read = (op == OP_READ);

    assign ch          = nc_reg[CH_W-1:0];
    assign active      = (nc_reg < chan_count_reg) && (32'(nc_reg) < MAX_CHANNELS);
    assign rp_in_table = (32'(rp_reg) < MAX_RANGES);
    assign rp_in_use   = rp_in_table && (rp_reg < range_count_reg);
    assign cur_start   = starts_reg[rp_reg[RIDX_W-1:0]];
    assign cur_end     = ends_reg[rp_reg[RIDX_W-1:0]];
    assign rd_ok       = (COUNT_W'(slot) < ll_reg) && (32'(slot) < MAX_CHANNELS);

    always_comb
    begin
        nc_next   = nc_reg;
        rp_next   = rp_reg;
        skip_next = skip_reg;
        ll_next   = ll_reg;
        excluded  = 1'b0;
        ram_we    = 1'b0;
        chan_c    = '0;
        kept_c    = 1'b0;
        pos_c     = '0;
        if (cmd.accept)
        begin
            case (op)
                OP_CLEAR:
                begin
                    nc_next   = '0;
                    rp_next   = '0;
                    skip_next = 1'b0;
                    ll_next   = '0;
                end
                OP_BUILD:
                begin
                    if (active)
                    begin
                        if (mode_reg == MODE_RANGES)
                        begin
                            if (skip_reg)
                            begin
                                excluded = 1'b1;
                                if (rp_in_table && (FIELD_W'(ch) == cur_end))
                                begin
                                    skip_next = 1'b0;
                                    rp_next   = rp_reg + 1'b1;
                                end
                            end
                            else if (rp_in_use && (FIELD_W'(ch) == cur_start))
                            begin
                                excluded = 1'b1;
                                if (FIELD_W'(ch) == cur_end)
                                begin
                                    rp_next = rp_reg + 1'b1;
                                end
                                else
                                begin
                                    skip_next = 1'b1;
                                end
                            end
                        end
                        else if (mode_reg == MODE_MASK)
                        begin
                            excluded = mask_reg[MIDX_W'(ch >> 3)][ch[2:0]];
                        end
                        chan_c = FIELD_W'(ch);
                        if (!excluded && (32'(ll_reg) < MAX_CHANNELS))
                        begin
                            ram_we  = 1'b1;
                            kept_c  = 1'b1;
                            pos_c   = FIELD_W'(ll_reg);
                            ll_next = ll_reg + 1'b1;
                        end
                        nc_next = nc_reg + 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
        done_c = !((nc_next < chan_count_reg) && (32'(nc_next) < MAX_CHANNELS));
    end

    ucl_list_ram #(
        .WIDTH (CH_W),
        .DEPTH (MAX_CHANNELS)
    ) u_list_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ll_reg[CH_W-1:0]),
        .wdata (ch),
        .raddr (CH_W'(slot)),
        .rdata (ram_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chan_count_reg  <= '0;
            mode_reg        <= '0;
            range_count_reg <= '0;
            nc_reg          <= '0;
            rp_reg          <= '0;
            skip_reg        <= 1'b0;
            ll_reg          <= '0;
            for (int i = 0; i < MAX_RANGES; i++)
            begin
                starts_reg[i] <= '0;
                ends_reg[i]   <= '0;
            end
            for (int i = 0; i < MASK_BYTES; i++)
            begin
                mask_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_CHANNEL_COUNT:  chan_count_reg  <= cfg_data;
                    CFG_EXCLUSION_MODE: mode_reg        <= cfg_data[MODE_W-1:0];
                    CFG_RANGE_COUNT:    range_count_reg <= cfg_data[RCOUNT_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.accept && (op == OP_LOAD_RANGE) && (32'(slot) < MAX_RANGES))
            begin
                starts_reg[RIDX_W'(slot)] <= range_start;
                ends_reg[RIDX_W'(slot)]   <= range_end;
            end
            if (cmd.accept && (op == OP_LOAD_MASK) && (32'(slot) < MASK_BYTES))
            begin
                mask_reg[MIDX_W'(slot)] <= mask_bits;
            end
            nc_reg   <= nc_next;
            rp_reg   <= rp_next;
            skip_reg <= skip_next;
            ll_reg   <= ll_next;
        end
    end

    // Result register; a list read is loaded in the cycle after its acceptance, from the RAM output.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            rd_valid_reg <= rd_ok;
        end
        if (cmd.accept && !stat.is_read)
        begin
            chan_reg  <= chan_c;
            kept_reg  <= kept_c;
            pos_reg   <= pos_c;
            done_reg  <= done_c;
            count_reg <= COUNT_FIELD_W'(ll_next);
            valid_reg <= 1'b0;
        end
        else if (cmd.rd_done)
        begin
            chan_reg  <= rd_valid_reg ? FIELD_W'(ram_q) : '0;
            kept_reg  <= 1'b0;
            pos_reg   <= '0;
            done_reg  <= done_c;
            count_reg <= COUNT_FIELD_W'(ll_reg);
            valid_reg <= rd_valid_reg;
        end
    end

    assign channel      = chan_reg;
    assign kept         = kept_reg;
    assign position     = pos_reg;
    assign done_res     = done_reg;
    assign usable_count = count_reg;
    assign entry_valid  = valid_reg;

endmodule

[rtl/usable_channel_list_builder_core.sv]
// Timing: a load, clear or build transaction is written to the result register on acceptance;
// a list read is written only after the registered RAM read port has delivered the entry.
// Throughput: one transaction per cycle while the result is not stalled, except a read, which
// holds the input while the list RAM is accessed.
// Reset: asynchronous, active low; clears configuration, exclusion tables and build state.
// The list RAM has no reset and needs no clearing pass.
module usable_channel_list_builder_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [ucl_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ucl_pkg::CFG_W-1:0]         cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [ucl_pkg::OP_W-1:0]          operation,
    input  logic [ucl_pkg::FIELD_W-1:0]       slot,
    input  logic [ucl_pkg::FIELD_W-1:0]       range_start,
    input  logic [ucl_pkg::FIELD_W-1:0]       range_end,
    input  logic [ucl_pkg::FIELD_W-1:0]       mask_bits,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [ucl_pkg::FIELD_W-1:0]       channel,
    output logic                              kept,
    output logic [ucl_pkg::FIELD_W-1:0]       position,
    output logic                              done_res,
    output logic [ucl_pkg::COUNT_FIELD_W-1:0] usable_count,
    output logic                              entry_valid
);
    import ucl_pkg::*;

    ucl_cmd_t  cmd;
    ucl_stat_t stat;

    ucl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    ucl_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .operation    (operation),
        .slot         (slot),
        .range_start  (range_start),
        .range_end    (range_end),
        .mask_bits    (mask_bits),
        .cmd          (cmd),
        .stat         (stat),
        .channel      (channel),
        .kept         (kept),
        .position     (position),
        .done_res     (done_res),
        .usable_count (usable_count),
        .entry_valid  (entry_valid)
    );

endmodule

[rtl/ucl_checker.sv]
// Port-level assertions for the usable channel list builder and their bind.
module ucl_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              out_valid,
    input logic                              out_stall,
    input logic [ucl_pkg::FIELD_W-1:0]       channel,
    input logic                              kept,
    input logic [ucl_pkg::FIELD_W-1:0]       position,
    input logic                              done_res,
    input logic [ucl_pkg::COUNT_FIELD_W-1:0] usable_count,
    input logic                              entry_valid
);
    import ucl_pkg::*;

    // A stalled result transaction keeps its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(channel) && $stable(kept)
            && $stable(position) && $stable(done_res) && $stable(usable_count)
            && $stable(entry_valid))
        else $error("result changed while stalled");

    // A build result and a list read result are never the same transaction.
    a_kept_not_read: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kept |-> !entry_valid)
        else $error("kept and entry_valid both set");

    // A position is reported only for a channel that was appended.
    a_pos_only_kept: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !kept |-> position == '0)
        else $error("position set without kept");

    // An appended channel sits below the reported list length.
    a_kept_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kept |-> usable_count == COUNT_FIELD_W'(position) + 1'b1)
        else $error("usable count does not follow the appended position");

endmodule

bind usable_channel_list_builder_core ucl_checker u_ucl_checker (.*);
